// ----- src/tdsd_pkg.sv -----
`default_nettype none

package tdsd_pkg;

    localparam int PWM_STEPS  = 32;
    localparam int NUM_DIGITS = 3;

    localparam int PHASE_W  = (PWM_STEPS > 1) ? $clog2(PWM_STEPS) : 1;
    localparam int BRIGHT_W = 6;
    localparam int CMP_W    = (PHASE_W > BRIGHT_W) ? PHASE_W : BRIGHT_W;
    localparam int SCORE_W  = 10;
    localparam int CFG_IDX_W = 2;

    localparam logic [PHASE_W-1:0]  PHASE_LAST    = PHASE_W'(PWM_STEPS - 1);
    localparam logic [BRIGHT_W-1:0] BRIGHT_RESET  = 6'd32;
    localparam logic [SCORE_W-1:0]  SCORE_MAX     = 10'd999;

    localparam logic [1:0] SLOT_ONES     = 2'd0;
    localparam logic [1:0] SLOT_TENS     = 2'd1;
    localparam logic [1:0] SLOT_HUNDREDS = 2'(NUM_DIGITS - 1);

    localparam logic [1:0] BYTES_PER_WORD = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_BRIGHT_ONES     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BRIGHT_TENS     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BRIGHT_HUNDREDS = 2'd2;

    localparam logic [2:0] EN_ONES     = 3'b110;
    localparam logic [2:0] EN_TENS     = 3'b101;
    localparam logic [2:0] EN_HUNDREDS = 3'b011;
    localparam logic [2:0] EN_OFF      = 3'b111;
    localparam logic [6:0] SEG_OFF     = 7'h7F;

    typedef enum logic [1:0] {
        OP_TICK    = 2'd0,
        OP_BUTTONS = 2'd1,
        OP_ADDRESS = 2'd2,
        OP_DATA    = 2'd3
    } opcode_t;

    typedef struct packed {
        opcode_t     opcode;
        logic [5:0]  buttons;
        logic [7:0]  data_byte;
    } in_item_t;

    typedef struct packed {
        logic [2:0]         digit_enable_n;
        logic [6:0]         segments_n;
        logic [SCORE_W-1:0] score_value;
        logic               overflow;
    } out_item_t;

    typedef struct packed {
        logic [3:0] hundreds;
        logic [3:0] tens;
        logic [3:0] ones;
    } bcd_t;

    typedef struct packed {
        bcd_t               score;
        logic [1:0]         slot;
        logic [PHASE_W-1:0] phase;
        logic [7:0]         low_byte;
        logic [7:0]         high_byte;
        logic [1:0]         byte_count;
    } state_t;

    typedef struct packed {
        logic [BRIGHT_W-1:0] ones;
        logic [BRIGHT_W-1:0] tens;
        logic [BRIGHT_W-1:0] hundreds;
    } bright_t;

    function automatic logic [6:0] seg_decode(input logic [3:0] digit);
        logic [6:0] seg;
        case (digit)
            4'd0:    seg = 7'b1000000;
            4'd1:    seg = 7'b1111001;
            4'd2:    seg = 7'b0100100;
            4'd3:    seg = 7'b0110000;
            4'd4:    seg = 7'b0011001;
            4'd5:    seg = 7'b0010010;
            4'd6:    seg = 7'b0000010;
            4'd7:    seg = 7'b1111000;
            4'd8:    seg = 7'b0000000;
            4'd9:    seg = 7'b0010000;
            default: seg = SEG_OFF;
        endcase
        return seg;
    endfunction

    function automatic logic [3:0] digit_step(input logic [3:0] d, input logic up,
                                              input logic down);
        logic [3:0] r;
        r = d;
        if (up && !down) begin
            r = (d >= 4'd9) ? 4'd0 : d + 4'd1;
        end else if (down && !up) begin
            r = (d == 4'd0) ? 4'd9 : d - 4'd1;
        end
        return r;
    endfunction

    // The value is at most 999, so the hundreds and tens digits are each found by nine parallel compares.
    function automatic bcd_t bin_to_bcd(input logic [SCORE_W-1:0] v);
        bcd_t       r;
        logic [3:0] h;
        logic [3:0] t;
        logic [6:0] rem_h;
        logic [3:0] rem_t;
        h = 4'd0;
        for (int k = 1; k <= 9; k++) begin
            if (v >= SCORE_W'(k * 100)) begin
                h = 4'(k);
            end
        end
        rem_h = 7'(v - SCORE_W'(h) * SCORE_W'(100));
        t = 4'd0;
        for (int k = 1; k <= 9; k++) begin
            if (rem_h >= 7'(k * 10)) begin
                t = 4'(k);
            end
        end
        rem_t = 4'(rem_h - 7'(t) * 7'd10);
        r.hundreds = h;
        r.tens     = t;
        r.ones     = rem_t;
        return r;
    endfunction

    function automatic logic [SCORE_W-1:0] bcd_to_bin(input bcd_t b);
        return SCORE_W'(b.hundreds) * SCORE_W'(100) + SCORE_W'(b.tens) * SCORE_W'(10)
             + SCORE_W'(b.ones);
    endfunction

endpackage

`default_nettype wire

// ----- src/tdsd_update.sv -----
`default_nettype none

module tdsd_update (
    input  wire tdsd_pkg::in_item_t  item,
    input  wire tdsd_pkg::state_t    state,
    input  wire tdsd_pkg::bright_t   bright,
    output tdsd_pkg::state_t         state_next,
    output tdsd_pkg::out_item_t      result_next
);

    logic [15:0]                     word;
    logic [tdsd_pkg::SCORE_W-1:0]    word_sat;
    logic                            ovf;
    logic [tdsd_pkg::BRIGHT_W-1:0]   sel_bright;
    logic [3:0]                      sel_digit;
    logic [2:0]                      sel_enable;
    logic                            lit;

    always_comb
    begin
        state_next = state;
        ovf        = 1'b0;
        word       = {state.high_byte, state.low_byte};
        word_sat   = tdsd_pkg::SCORE_MAX;
        unique case (item.opcode)
            tdsd_pkg::OP_TICK:
            begin
                if (state.phase == tdsd_pkg::PHASE_LAST)
                begin
                    state_next.phase = '0;
                    state_next.slot  = (state.slot >= tdsd_pkg::SLOT_HUNDREDS)
                                     ? tdsd_pkg::SLOT_ONES : state.slot + 2'd1;
                end
                else
                begin
                    state_next.phase = state.phase + tdsd_pkg::PHASE_W'(1);
                end
            end
            tdsd_pkg::OP_BUTTONS:
            begin
                state_next.score.ones     = tdsd_pkg::digit_step(state.score.ones,
                                                item.buttons[0], item.buttons[1]);
                state_next.score.tens     = tdsd_pkg::digit_step(state.score.tens,
                                                item.buttons[2], item.buttons[3]);
                state_next.score.hundreds = tdsd_pkg::digit_step(state.score.hundreds,
                                                item.buttons[4], item.buttons[5]);
            end
            tdsd_pkg::OP_ADDRESS:
            begin
                state_next.byte_count = 2'd0;
            end
            tdsd_pkg::OP_DATA:
            begin
                if (state.byte_count < tdsd_pkg::BYTES_PER_WORD)
                begin
                    if (state.byte_count == 2'd0)
                    begin
                        state_next.low_byte = item.data_byte;
                    end
                    else
                    begin
                        state_next.high_byte = item.data_byte;
                    end
                    state_next.byte_count = state.byte_count + 2'd1;
                    word = {state_next.high_byte, state_next.low_byte};
                    if (word > 16'(tdsd_pkg::SCORE_MAX))
                    begin
                        ovf = 1'b1;
                    end
                    else
                    begin
                        word_sat = word[tdsd_pkg::SCORE_W-1:0];
                    end
                    state_next.score = tdsd_pkg::bin_to_bcd(word_sat);
                end
            end
        endcase
    end

    always_comb
    begin
        unique case (state_next.slot)
            tdsd_pkg::SLOT_TENS:
            begin
                sel_bright = bright.tens;
                sel_digit  = state_next.score.tens;
                sel_enable = tdsd_pkg::EN_TENS;
            end
            tdsd_pkg::SLOT_HUNDREDS:
            begin
                sel_bright = bright.hundreds;
                sel_digit  = state_next.score.hundreds;
                sel_enable = tdsd_pkg::EN_HUNDREDS;
            end
            default:
            begin
                sel_bright = bright.ones;
                sel_digit  = state_next.score.ones;
                sel_enable = tdsd_pkg::EN_ONES;
            end
        endcase
        lit = tdsd_pkg::CMP_W'(state_next.phase) < tdsd_pkg::CMP_W'(sel_bright);
        result_next.digit_enable_n = lit ? sel_enable : tdsd_pkg::EN_OFF;
        result_next.segments_n     = lit ? tdsd_pkg::seg_decode(sel_digit)
                                         : tdsd_pkg::SEG_OFF;
        result_next.score_value    = tdsd_pkg::bcd_to_bin(state_next.score);
        result_next.overflow       = ovf;
    end

endmodule

`default_nettype wire

// ----- src/three_digit_score_display_driver.sv -----
// Three-digit score display driver for a multiplexed common-anode display.
// Requests arrive on the in channel (in_valid, in_stall, in_item): a tick
// advances the brightness phase and the digit scan, a button request steps the
// decimal digits, and bus address and data bytes write the score.
// Every accepted request yields exactly one result on the out channel
// (out_valid, out_stall, out_item) with the digit selects, the segment pattern,
// the score and the saturation flag, all taken from the state after the request.
// An accepted request is held in the input register, and its result is registered in
// the result register through the single update stage between them; one request is taken
// in every cycle while the receiver does not stall.
// While the receiver stalls, the result is held and one further request waits
// in the input register; after that in_stall rises until the result is taken.
// Brightness registers are written on the cfg channel, which is always ready;
// an index beyond the three registers is ignored.
// Reset clears the score, the byte latches and the scan to the ones digit at
// phase zero, and sets all three brightness values to 32.
`default_nettype none

module three_digit_score_display_driver (
    input  wire                                     clk,
    input  wire                                     rst_n,
    input  wire                                     in_valid,
    output logic                                    in_stall,
    input  wire tdsd_pkg::in_item_t                 in_item,
    output logic                                    out_valid,
    input  wire                                     out_stall,
    output tdsd_pkg::out_item_t                     out_item,
    input  wire                                     cfg_valid,
    output logic                                    cfg_ready,
    input  wire [tdsd_pkg::CFG_IDX_W-1:0]           cfg_index,
    input  wire [tdsd_pkg::BRIGHT_W-1:0]            cfg_data
);

    tdsd_pkg::bright_t    bright_reg;
    tdsd_pkg::state_t     state_reg;
    tdsd_pkg::state_t     state_next;
    tdsd_pkg::in_item_t   in_item_reg;
    tdsd_pkg::out_item_t  out_item_reg;
    tdsd_pkg::out_item_t  out_item_next;
    logic                 in_valid_reg;
    logic                 out_valid_reg;
    logic                 advance;
    logic                 take_in;

    assign advance   = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = in_valid_reg && !advance;
    assign take_in   = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;
    assign cfg_ready = 1'b1;

    tdsd_update u_update (
        .item        (in_item_reg),
        .state       (state_reg),
        .bright      (bright_reg),
        .state_next  (state_next),
        .result_next (out_item_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bright_reg.ones     <= tdsd_pkg::BRIGHT_RESET;
            bright_reg.tens     <= tdsd_pkg::BRIGHT_RESET;
            bright_reg.hundreds <= tdsd_pkg::BRIGHT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                tdsd_pkg::REG_BRIGHT_ONES:     bright_reg.ones     <= cfg_data;
                tdsd_pkg::REG_BRIGHT_TENS:     bright_reg.tens     <= cfg_data;
                tdsd_pkg::REG_BRIGHT_HUNDREDS: bright_reg.hundreds <= cfg_data;
                default:                       bright_reg          <= bright_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.score      <= '0;
            state_reg.slot       <= tdsd_pkg::SLOT_ONES;
            state_reg.phase      <= '0;
            state_reg.low_byte   <= '0;
            state_reg.high_byte  <= '0;
            state_reg.byte_count <= '0;
            in_valid_reg         <= 1'b0;
            out_valid_reg        <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                state_reg <= state_next;
            end
            if (take_in)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_item_reg  <= '0;
            out_item_reg <= '0;
        end
        else
        begin
            if (take_in)
            begin
                in_item_reg <= in_item;
            end
            if (advance)
            begin
                out_item_reg <= out_item_next;
            end
        end
    end

    // The score held in decimal digits never leaves the range of a digit.
    a_digits_decimal: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.score.ones <= 4'd9 && state_reg.score.tens <= 4'd9
        && state_reg.score.hundreds <= 4'd9)
        else $error("score digit out of decimal range");

    a_slot_valid: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.slot != 2'd3)
        else $error("scan slot reached an unused value");

    a_overflow_saturates: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.overflow |-> out_item.score_value == tdsd_pkg::SCORE_MAX)
        else $error("overflow flagged without a saturated score");

    a_dark_consistent: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((out_item.digit_enable_n == tdsd_pkg::EN_OFF)
                       == (out_item.segments_n == tdsd_pkg::SEG_OFF))
                      && $onehot0(~out_item.digit_enable_n))
        else $error("digit selects and segments disagree");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall && in_valid_reg)
        else $error("input stalled while the result register could move");

endmodule

`default_nettype wire

// ----- tb/score_display_checker.sv -----
`timescale 1ns / 1ps

module score_display_checker (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire                              in_valid,
    input  wire                              in_stall,
    input  wire tdsd_pkg::in_item_t          in_item,
    input  wire                              out_valid,
    input  wire                              out_stall,
    input  wire tdsd_pkg::out_item_t         out_item,
    input  wire                              cfg_valid,
    input  wire                              cfg_ready,
    input  wire [tdsd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire [tdsd_pkg::BRIGHT_W-1:0]     cfg_data,
    output int                               mismatches,
    output int                               awaited
);

    import tdsd_pkg::*;

    logic [SCORE_W-1:0] score;
    logic [1:0]         slot;
    logic [PHASE_W-1:0] phase;
    logic [7:0]         low_byte;
    logic [7:0]         high_byte;
    logic [1:0]         byte_count;
    bright_t            bright;

    out_item_t          shown_q[$];

    function automatic int nudge(input int d, input logic up, input logic down);
        if (up && !down) begin
            return (d == 9) ? 0 : d + 1;
        end
        if (down && !up) begin
            return (d == 0) ? 9 : d - 1;
        end
        return d;
    endfunction

    function automatic logic [6:0] glyph(input int d);
        logic [6:0] g;
        case (d)
            0:       g = 7'h40;
            1:       g = 7'h79;
            2:       g = 7'h24;
            3:       g = 7'h30;
            4:       g = 7'h19;
            5:       g = 7'h12;
            6:       g = 7'h02;
            7:       g = 7'h78;
            8:       g = 7'h00;
            default: g = 7'h10;
        endcase
        return g;
    endfunction

    // Applies one request to the display state and works out what the block shows after it.
    task automatic advance_display(input in_item_t req, output out_item_t shown);
        int         word;
        int         hund;
        int         tens;
        int         ones;
        int         digit;
        int         limit;
        logic [2:0] select;
        shown.overflow = 1'b0;
        case (req.opcode)
            OP_TICK:
            begin
                if (phase == PHASE_LAST)
                begin
                    phase = '0;
                    slot  = (slot >= SLOT_HUNDREDS) ? SLOT_ONES : slot + 2'd1;
                end
                else
                begin
                    phase = phase + 1'b1;
                end
            end
            OP_BUTTONS:
            begin
                if (req.buttons != '0)
                begin
                    hund  = int'(score) / 100;
                    tens  = (int'(score) / 10) % 10;
                    ones  = int'(score) % 10;
                    ones  = nudge(ones, req.buttons[0], req.buttons[1]);
                    tens  = nudge(tens, req.buttons[2], req.buttons[3]);
                    hund  = nudge(hund, req.buttons[4], req.buttons[5]);
                    score = SCORE_W'(hund * 100 + tens * 10 + ones);
                end
            end
            OP_ADDRESS:
            begin
                byte_count = '0;
            end
            default:
            begin
                if (byte_count < BYTES_PER_WORD)
                begin
                    if (byte_count == 2'd0)
                    begin
                        low_byte = req.data_byte;
                    end
                    else
                    begin
                        high_byte = req.data_byte;
                    end
                    byte_count = byte_count + 2'd1;
                    word = int'(low_byte) + 256 * int'(high_byte);
                    if (word > int'(SCORE_MAX))
                    begin
                        word           = int'(SCORE_MAX);
                        shown.overflow = 1'b1;
                    end
                    score = SCORE_W'(word);
                end
            end
        endcase

        case (slot)
            SLOT_TENS:
            begin
                limit  = int'(bright.tens);
                digit  = (int'(score) / 10) % 10;
                select = EN_TENS;
            end
            SLOT_HUNDREDS:
            begin
                limit  = int'(bright.hundreds);
                digit  = (int'(score) / 100) % 10;
                select = EN_HUNDREDS;
            end
            default:
            begin
                limit  = int'(bright.ones);
                digit  = int'(score) % 10;
                select = EN_ONES;
            end
        endcase
        if (int'(phase) < limit)
        begin
            shown.digit_enable_n = select;
            shown.segments_n     = glyph(digit);
        end
        else
        begin
            shown.digit_enable_n = EN_OFF;
            shown.segments_n     = SEG_OFF;
        end
        shown.score_value = score;
    endtask

    task automatic compare_field(input string field, input int want, input int got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        out_item_t due;
        out_item_t next_shown;
        if (!rst_n)
        begin
            score         = '0;
            slot          = SLOT_ONES;
            phase         = '0;
            low_byte      = '0;
            high_byte     = '0;
            byte_count    = '0;
            bright.ones     = BRIGHT_RESET;
            bright.tens     = BRIGHT_RESET;
            bright.hundreds = BRIGHT_RESET;
            shown_q.delete();
            mismatches    = 0;
            awaited       = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (shown_q.size() == 0)
                begin
                    $display("%0t: result with no request pending, expected none, got %h",
                             $time, out_item);
                    mismatches++;
                end
                else
                begin
                    due = shown_q.pop_front();
                    compare_field("digit_enable_n", int'(due.digit_enable_n),
                                  int'(out_item.digit_enable_n));
                    compare_field("segments_n", int'(due.segments_n),
                                  int'(out_item.segments_n));
                    compare_field("score_value", int'(due.score_value),
                                  int'(out_item.score_value));
                    compare_field("overflow", int'(due.overflow),
                                  int'(out_item.overflow));
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_BRIGHT_ONES:     bright.ones     = cfg_data;
                    REG_BRIGHT_TENS:     bright.tens     = cfg_data;
                    REG_BRIGHT_HUNDREDS: bright.hundreds = cfg_data;
                    default:             ;
                endcase
            end
            if (in_valid && !in_stall)
            begin
                advance_display(in_item, next_shown);
                shown_q.push_back(next_shown);
            end
            awaited = shown_q.size();
        end
    end

endmodule

// ----- tb/three_digit_score_display_driver_test.sv -----
`timescale 1ns / 1ps

module three_digit_score_display_driver_test;

    import tdsd_pkg::*;

    localparam int                   WATCHDOG_LIMIT = 2000;
    localparam int                   PHASES         = 7;
    localparam int                   PHASE_REQUESTS = 262;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE      = 2'd3;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    in_item_t             in_item;
    logic                 out_valid;
    logic                 out_stall;
    out_item_t            out_item;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [BRIGHT_W-1:0]  cfg_data;

    int                   mismatches;
    int                   awaited;
    int                   gap_percent   = 0;
    int                   stall_percent = 0;

    three_digit_score_display_driver dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    score_display_checker checker_inst (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_item    (in_item),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_item   (out_item),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .mismatches (mismatches),
        .awaited    (awaited)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    task automatic send_request(input opcode_t op, input logic [5:0] btn,
                                input logic [7:0] byte_val);
        int gap;
        if (gap_percent != 0 && $urandom_range(1, 100) <= gap_percent)
        begin
            gap      = $urandom_range(1, 5);
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_item.opcode    = op;
        in_item.buttons   = btn;
        in_item.data_byte = byte_val;
        in_valid          = 1'b1;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic wait_drained;
        in_valid = 1'b0;
        while (awaited != 0) @(negedge clk);
    endtask

    task automatic write_brightness(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [BRIGHT_W-1:0] val);
        cfg_index = idx;
        cfg_data  = val;
        cfg_valid = 1'b1;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // A mix of ticks, button requests, complete bus writes of an address and two bytes, and stray bytes and addresses.
    task automatic random_traffic(input int quota);
        int done;
        int pick;
        done = 0;
        while (done < quota)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 45)
            begin
                send_request(OP_TICK, 6'($urandom), 8'($urandom));
                done += 1;
            end
            else if (pick < 65)
            begin
                send_request(OP_BUTTONS,
                             (pick < 52) ? 6'(1 << $urandom_range(0, 5)) : 6'($urandom),
                             8'($urandom));
                done += 1;
            end
            else if (pick < 85)
            begin
                send_request(OP_ADDRESS, 6'($urandom), 8'($urandom));
                send_request(OP_DATA, 6'($urandom), 8'($urandom));
                send_request(OP_DATA, 6'($urandom),
                             ($urandom_range(0, 9) < 7) ? 8'($urandom_range(0, 3))
                                                        : 8'($urandom));
                done += 3;
            end
            else if (pick < 93)
            begin
                send_request(OP_DATA, 6'($urandom), 8'($urandom));
                done += 1;
            end
            else
            begin
                send_request(OP_ADDRESS, 6'($urandom), 8'($urandom));
                done += 1;
            end
        end
    endtask

    initial
    begin
        int burst;
        burst     = 0;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (burst > 0)
            begin
                out_stall = 1'b1;
                burst--;
            end
            else if (stall_percent != 0 && $urandom_range(1, 100) <= stall_percent)
            begin
                burst     = $urandom_range(1, 5) - 1;
                out_stall = 1'b1;
            end
            else
            begin
                out_stall = 1'b0;
            end
        end
    end

    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
            end
        end
        $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_item   = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        gap_percent   = 10;
        stall_percent = 10;
        send_request(OP_BUTTONS, 6'b000000, 8'h00);
        send_request(OP_BUTTONS, 6'b101010, 8'hFF);
        send_request(OP_BUTTONS, 6'b010101, 8'h00);
        send_request(OP_BUTTONS, 6'b111111, 8'hFF);
        send_request(OP_BUTTONS, 6'b000001, 8'h00);
        send_request(OP_BUTTONS, 6'b001000, 8'h00);
        send_request(OP_DATA, 6'b111111, 8'hFF);
        send_request(OP_DATA, 6'b000000, 8'hFF);
        send_request(OP_DATA, 6'b000000, 8'h12);
        send_request(OP_ADDRESS, 6'b111111, 8'hAA);
        send_request(OP_DATA, 6'b000000, 8'hE7);
        send_request(OP_DATA, 6'b000000, 8'h03);
        send_request(OP_ADDRESS, 6'b000000, 8'h00);
        send_request(OP_DATA, 6'b000000, 8'h00);
        send_request(OP_DATA, 6'b000000, 8'h00);
        send_request(OP_TICK, 6'b111111, 8'hFF);
        send_request(OP_TICK, 6'b000000, 8'h00);

        for (int p = 0; p < PHASES; p++)
        begin
            wait_drained();
            case (p)
                0:
                begin
                    write_brightness(REG_BRIGHT_ONES, 6'd0);
                    write_brightness(REG_BRIGHT_TENS, 6'd0);
                    write_brightness(REG_BRIGHT_HUNDREDS, 6'd0);
                end
                1:
                begin
                    write_brightness(REG_BRIGHT_ONES, 6'd63);
                    write_brightness(REG_BRIGHT_TENS, 6'd63);
                    write_brightness(REG_BRIGHT_HUNDREDS, 6'd63);
                    gap_percent   = 0;
                    stall_percent = 30;
                end
                2:
                begin
                    write_brightness(REG_BRIGHT_ONES, 6'd1);
                    write_brightness(REG_BRIGHT_TENS, 6'd31);
                    write_brightness(REG_BRIGHT_HUNDREDS, 6'd32);
                    gap_percent   = 30;
                    stall_percent = 0;
                end
                3:
                begin
                    write_brightness(REG_BRIGHT_ONES, 6'd33);
                    write_brightness(REG_BRIGHT_TENS, 6'd0);
                    write_brightness(REG_BRIGHT_HUNDREDS, 6'd17);
                    write_brightness(REG_SPARE, 6'h2A);
                    gap_percent   = 10;
                    stall_percent = 10;
                end
                default:
                begin
                    write_brightness(REG_BRIGHT_ONES, 6'($urandom_range(0, 63)));
                    write_brightness(REG_BRIGHT_TENS, 6'($urandom_range(0, 63)));
                    write_brightness(REG_BRIGHT_HUNDREDS, 6'($urandom_range(0, 63)));
                    gap_percent   = (p == PHASES - 1) ? 0 : 20;
                    stall_percent = (p == PHASES - 1) ? 0 : 20;
                end
            endcase
            random_traffic(PHASE_REQUESTS);
        end

        wait_drained();
        repeat (4) @(negedge clk);
        if (mismatches == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
